@@ hw/rtl/float_iq_to_int16_pair_packer_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the float IQ to int16 pair packer
// Expects signals named clock and reset in the using scope.
// ----------------------------------------------------------------------------
`ifndef FLOAT_IQ_TO_INT16_PAIR_PACKER_ASSERT_SVH
`define FLOAT_IQ_TO_INT16_PAIR_PACKER_ASSERT_SVH

// Same-cycle implication
`define FIP_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fip assertion failed");

// Next-cycle implication
`define FIP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fip assertion failed");

`endif

@@ hw/rtl/fip_pkg.sv @@
// ----------------------------------------------------------------------------
// fip_pkg
// Types and constants shared by the float IQ to int16 pair packer.
// ----------------------------------------------------------------------------
package fip_pkg;

   localparam logic [7:0]         EXP_MAX     = 8'hFF;
   localparam logic signed [9:0]  EXP_OFFSET  = 10'sd300;
   localparam logic [31:0]        SCALE_RESET = 32'h46FFFE00;
   localparam logic [15:0]        INT16_MIN   = 16'h8000;
   localparam logic [15:0]        INT16_MAX   = 16'h7FFF;

   localparam logic [1:0] FMT_LE_ITEM32 = 2'd0;
   localparam logic [1:0] FMT_BE_ITEM32 = 2'd1;
   localparam logic [1:0] FMT_NATIVE    = 2'd2;

   localparam logic CSR_SCALE  = 1'b0;
   localparam logic CSR_FORMAT = 1'b1;

   typedef struct packed {
      logic               special;
      logic               sign;
      logic signed [9:0]  sexp;
      logic [47:0]        mant;
   } fip_mul_type;

   typedef struct packed {
      logic               special;
      logic               sign;
      logic               zero;
      logic signed [10:0] mexp;
      logic [23:0]        rmant;
   } fip_rnd_type;

endpackage

@@ hw/rtl/fip_req_if.sv @@
// ----------------------------------------------------------------------------
// fip_req_if
// Input channel: one complex float sample per transaction.
// ----------------------------------------------------------------------------
interface fip_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] real_bits;
   logic [31:0] imag_bits;

   modport source (output valid, output real_bits, output imag_bits, input ready);
   modport sink   (input valid, input real_bits, input imag_bits, output ready);
endinterface

@@ hw/rtl/fip_rsp_if.sv @@
// ----------------------------------------------------------------------------
// fip_rsp_if
// Result channel: one packed int16 pair per transaction.
// ----------------------------------------------------------------------------
interface fip_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] packed_word;

   modport source (output valid, output packed_word, input ready);
   modport sink   (input valid, input packed_word, output ready);
endinterface

@@ hw/rtl/fip_csr.sv @@
// ----------------------------------------------------------------------------
// fip_csr
// APB register file: scale factor and output format.
// ----------------------------------------------------------------------------
module fip_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [31:0] scale_ff,
   output logic [1:0]  format_ff
);
   logic        wr_en;
   logic [31:0] scale_in;
   logic [1:0]  format_in;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      scale_in  = scale_ff;
      format_in = format_ff;
      if (wr_en) begin
         unique case (paddr[2])
            fip_pkg::CSR_SCALE:  scale_in  = pwdata;
            fip_pkg::CSR_FORMAT: format_in = pwdata[1:0];
            default:             scale_in  = scale_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         fip_pkg::CSR_SCALE:  prdata = scale_ff;
         fip_pkg::CSR_FORMAT: prdata = {30'd0, format_ff};
         default:             prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= fip_pkg::SCALE_RESET;
         format_ff <= fip_pkg::FMT_LE_ITEM32;
      end else begin
         scale_ff  <= scale_in;
         format_ff <= format_in;
      end
   end
endmodule

@@ hw/rtl/fip_mul_lane.sv @@
// ----------------------------------------------------------------------------
// fip_mul_lane
// Unpacks one float part and the scale, multiplies the significands.
// ----------------------------------------------------------------------------
module fip_mul_lane (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [31:0]           value_bits,
   input  logic [31:0]           scale_bits,
   output fip_pkg::fip_mul_type  mul_ff
);
   logic [7:0]           a_exp;
   logic [7:0]           b_exp;
   logic [7:0]           a_e;
   logic [7:0]           b_e;
   logic [23:0]          a_m;
   logic [23:0]          b_m;
   fip_pkg::fip_mul_type mul_in;

   always_comb begin
      a_exp = value_bits[30:23];
      b_exp = scale_bits[30:23];
      a_m   = {|a_exp, value_bits[22:0]};
      b_m   = {|b_exp, scale_bits[22:0]};
      a_e   = (a_exp == 8'd0) ? 8'd1 : a_exp;
      b_e   = (b_exp == 8'd0) ? 8'd1 : b_exp;
      mul_in.special = (a_exp == fip_pkg::EXP_MAX) || (b_exp == fip_pkg::EXP_MAX);
      mul_in.sign    = value_bits[31] ^ scale_bits[31];
      mul_in.sexp    = signed'({2'b00, a_e}) + signed'({2'b00, b_e}) - fip_pkg::EXP_OFFSET;
      mul_in.mant    = {24'd0, a_m} * {24'd0, b_m};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mul_ff <= mul_in;
      end
   end
endmodule

@@ hw/rtl/fip_cvt_lane.sv @@
// ----------------------------------------------------------------------------
// fip_cvt_lane
// Rounds the product to single precision (registered), then rounds to
// integer with ties to even and saturates to int16, except that specials and magnitudes of 2^31 or more give INT16_MIN.
// ----------------------------------------------------------------------------
module fip_cvt_lane (
   input  logic                  clock,
   input  logic                  enable,
   input  fip_pkg::fip_mul_type  mul,
   output logic [15:0]           part
);
   logic [5:0]           lz;
   logic [47:0]          norm;
   logic                 round_up;
   logic [24:0]          rsum;
   logic signed [10:0]   mexp_v;
   fip_pkg::fip_rnd_type rnd_in;
   fip_pkg::fip_rnd_type rnd_ff;
   logic signed [10:0]   n_full;
   logic [47:0]          ext;
   logic                 iround;
   logic [16:0]          mag;
   logic [16:0]          neg;

   always_comb begin
      lz = 6'd48;
      for (int i = 0; i < 48; i++) begin
         if (mul.mant[i]) begin
            lz = 6'(47 - i);
         end
      end
      norm     = mul.mant << lz;
      round_up = norm[23] && ((|norm[22:0]) || norm[24]);
      rsum     = {1'b0, norm[47:24]} + {24'd0, round_up};
      mexp_v   = {mul.sexp[9], mul.sexp} + 11'sd47 - signed'({5'd0, lz})
                 + signed'({10'd0, rsum[24]});
      rnd_in.special = mul.special;
      rnd_in.sign    = mul.sign;
      rnd_in.zero    = (mul.mant == 48'd0);
      rnd_in.mexp    = mexp_v;
      rnd_in.rmant   = rsum[24] ? 24'h800000 : rsum[23:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rnd_ff <= rnd_in;
      end
   end

   always_comb begin
      n_full = 11'sd23 - rnd_ff.mexp;
      ext    = {rnd_ff.rmant, 24'd0} >> n_full[4:0];
      iround = ext[23] && ((|ext[22:0]) || ext[24]);
      mag    = {1'b0, ext[39:24]} + {16'd0, iround};
      neg    = 17'd0 - mag;
      if (rnd_ff.special || rnd_ff.mexp >= 11'sd31) begin
         part = fip_pkg::INT16_MIN;
      end else if (rnd_ff.mexp >= 11'sd15) begin
         part = rnd_ff.sign ? fip_pkg::INT16_MIN : fip_pkg::INT16_MAX;
      end else if (rnd_ff.zero || rnd_ff.mexp <= -11'sd2) begin
         part = 16'd0;
      end else if (rnd_ff.sign) begin
         part = neg[15:0];
      end else if (mag[15]) begin
         part = fip_pkg::INT16_MAX;
      end else begin
         part = mag[15:0];
      end
   end
endmodule

@@ hw/rtl/float_iq_to_int16_pair_packer.sv @@
// Pipeline: input, multiply, float-round and output registers in series from an
// accepted input transaction to result valid. Throughput: one complex sample per
// cycle while the result side is ready; a stall holds only registers with data,
// and the input waits only while all four hold data and rsp_ch.ready is low.
// Reset: synchronous, clears all valid flags, scale to 32767.0, format to
// little-endian item32.
// ----------------------------------------------------------------------------
// float_iq_to_int16_pair_packer
// Scales a complex float sample, converts both parts to saturated int16 and
// packs them into one 32-bit word.
// ----------------------------------------------------------------------------
`include "float_iq_to_int16_pair_packer_assert.svh"

module float_iq_to_int16_pair_packer (
   input  logic        clock,
   input  logic        reset,
   fip_req_if.sink     req_ch,
   fip_rsp_if.source   rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic                 v0_ff, v1_ff, v2_ff, v3_ff;
   logic                 v0_in, v1_in, v2_in, v3_in;
   logic                 en0, en1, en2, en3;
   logic [31:0]          real_ff, imag_ff;
   logic [31:0]          scale_ff;
   logic [1:0]           format_ff;
   fip_pkg::fip_mul_type mul_re, mul_im;
   logic [15:0]          part_re, part_im;
   logic [31:0]          word_le;
   logic [31:0]          word_in;
   logic [31:0]          word_ff;

   fip_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .scale_ff  (scale_ff),
      .format_ff (format_ff)
   );

   assign en3 = !v3_ff || rsp_ch.ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign en0 = !v0_ff || en1;
   assign req_ch.ready = en0;

   assign v0_in = en0 ? req_ch.valid : v0_ff;
   assign v1_in = en1 ? v0_ff : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en0) begin
         real_ff <= req_ch.real_bits;
         imag_ff <= req_ch.imag_bits;
      end
   end

   fip_mul_lane u_mul_re (
      .clock(clock), .enable(en1), .value_bits(real_ff), .scale_bits(scale_ff),
      .mul_ff(mul_re)
   );
   fip_mul_lane u_mul_im (
      .clock(clock), .enable(en1), .value_bits(imag_ff), .scale_bits(scale_ff),
      .mul_ff(mul_im)
   );

   fip_cvt_lane u_cvt_re (.clock(clock), .enable(en2), .mul(mul_re), .part(part_re));
   fip_cvt_lane u_cvt_im (.clock(clock), .enable(en2), .mul(mul_im), .part(part_im));

   always_comb begin
      word_le = {part_re, part_im};
      unique case (format_ff)
         fip_pkg::FMT_LE_ITEM32: word_in = word_le;
         fip_pkg::FMT_BE_ITEM32: word_in = {word_le[7:0], word_le[15:8],
                                            word_le[23:16], word_le[31:24]};
         default:                word_in = {part_im, part_re};
      endcase
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         word_ff <= word_in;
      end
   end

   assign rsp_ch.valid       = v3_ff;
   assign rsp_ch.packed_word = word_ff;

   `FIP_ASSERT_IMPL(a_ready_only_full, !req_ch.ready, v0_ff && v1_ff && v2_ff && v3_ff)
   `FIP_ASSERT_NEXT(a_s0_advances, v0_ff && en1, v1_ff)
   `FIP_ASSERT_NEXT(a_s2_to_out, v2_ff && en3, v3_ff)
   `FIP_ASSERT_NEXT(a_no_dup, rsp_ch.valid && rsp_ch.ready && !v2_ff, !rsp_ch.valid)
endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Float IQ to int16 pair packer testbench
// Drives complex float samples through the packer under several scale and
// layout settings and compares every packed word against a bit-level
// prediction of the scale, round-to-even and saturate path.
// ----------------------------------------------------------------------------
class pair_scoreboard;
   logic [31:0] scale;
   logic [1:0]  fmt;
   logic [31:0] pending_words[$];
   int          errors;

   function new();
      scale  = fip_pkg::SCALE_RESET;
      fmt    = fip_pkg::FMT_LE_ITEM32;
      errors = 0;
   endfunction

   function logic [63:0] round_shift(logic [63:0] x, int n);
      logic [63:0] q, rem, half;
      q    = x >> n;
      rem  = x & ((64'd1 << n) - 64'd1);
      half = 64'd1 << (n - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      return q;
   endfunction

   function int msb_index(logic [63:0] x);
      int i;
      for (i = 63; i > 0; i--) if (x[i]) return i;
      return 0;
   endfunction

   function logic [15:0] scaled_int16(logic [31:0] a, logic [31:0] b);
      logic [7:0]  xa, xb;
      logic [23:0] ma, mb;
      logic [47:0] p;
      logic [63:0] m, v;
      int          ea, eb, k, s, sh;
      xa = a[30:23];
      xb = b[30:23];
      if (xa == fip_pkg::EXP_MAX || xb == fip_pkg::EXP_MAX) return fip_pkg::INT16_MIN;
      ma = (xa == 0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
      mb = (xb == 0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
      ea = (xa == 0) ? -126 : int'(xa) - 127;
      eb = (xb == 0) ? -126 : int'(xb) - 127;
      if (ma == 0 || mb == 0) return 16'h0000;
      p = 48'(ma) * 48'(mb);
      k = msb_index(64'(p));
      if (k > 23) begin
         s = k - 23;
         m = round_shift(64'(p), s);
      end else begin
         s = 0;
         m = 64'(p);
      end
      sh = ea + eb - 46 + s;
      if (msb_index(m) + sh >= 31) return fip_pkg::INT16_MIN;
      if (sh >= 0) v = m << sh;
      else if (-sh > 62) v = 64'd0;
      else v = round_shift(m, -sh);
      if (!(a[31] ^ b[31])) begin
         if (v > 64'd32767) return fip_pkg::INT16_MAX;
         return v[15:0];
      end
      if (v >= 64'd32768) return fip_pkg::INT16_MIN;
      v = -v;
      return v[15:0];
   endfunction

   function void note_sample(logic [31:0] re_bits, logic [31:0] im_bits);
      logic [15:0] re, im;
      logic [31:0] w;
      re = scaled_int16(re_bits, scale);
      im = scaled_int16(im_bits, scale);
      w  = {re, im};
      if (fmt == fip_pkg::FMT_BE_ITEM32) w = {w[7:0], w[15:8], w[23:16], w[31:24]};
      else if (fmt != fip_pkg::FMT_LE_ITEM32) w = {im, re};
      pending_words.push_back(w);
   endfunction

   function void check_word(logic [31:0] w);
      logic [31:0] exp_w;
      if (pending_words.size() == 0) begin
         $display("%0t: unexpected packed_word, expected none, actual %h", $realtime, w);
         errors++;
         return;
      end
      exp_w = pending_words.pop_front();
      if (w !== exp_w) begin
         $display("%0t: packed_word mismatch, expected %h, actual %h", $realtime, exp_w, w);
         errors++;
      end
   endfunction
endclass

module testbench;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_ITEMS = 115;

   logic        clock;
   logic        reset;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          cycles;
   int          stall_left;
   bit          burst;

   fip_req_if req_if();
   fip_rsp_if rsp_if();
   pair_scoreboard sb;

   float_iq_to_int16_pair_packer DUT (
      .clock(clock), .reset(reset), .req_ch(req_if), .rsp_ch(rsp_if),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial sb = new();

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) sb.note_sample(req_if.real_bits, req_if.imag_bits);
         if (rsp_if.valid && rsp_if.ready) sb.check_word(rsp_if.packed_word);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (burst) begin
         rsp_if.ready <= 1'b1;
      end else begin
         rsp_if.ready <= 1'b1;
         case ($urandom_range(0, 99)) inside
            [0:69]:  stall_left <= 0;
            [70:94]: stall_left <= $urandom_range(1, 3);
            default: stall_left <= $urandom_range(10, 40);
         endcase
      end
   end

   function int pick_gap();
      if (burst) return 0;
      case ($urandom_range(0, 99)) inside
         [0:49]:  return 0;
         [50:89]: return $urandom_range(1, 3);
         default: return $urandom_range(10, 40);
      endcase
   endfunction

   function logic [31:0] half_int_bits(int n);
      logic [31:0] mag;
      int          p;
      mag = (n < 0) ? 32'(-2 * n + 1) : 32'(2 * n + 1);
      p = 31;
      while (!mag[p]) p--;
      mag = mag << (23 - p);
      return {n < 0, 8'(p - 1 + 127), mag[22:0]};
   endfunction

   function logic [31:0] random_float(logic [31:0] scale);
      int e;
      case ($urandom_range(0, 5))
         0: return $urandom();
         1, 2: begin
            e = 127 + 14 - (int'(scale[30:23]) - 127) + $urandom_range(0, 21) - 18;
            if (e < 0) e = 0;
            if (e > 254) e = 254;
            return {1'($urandom()), 8'(e), 23'($urandom())};
         end
         3: case ($urandom_range(0, 5))
               0: return {1'($urandom()), 31'h0};
               1: return {1'($urandom()), 8'hFF, 23'h0};
               2: return {1'($urandom()), 8'hFF, 23'($urandom() | 1)};
               3: return {1'($urandom()), 8'h00, 23'($urandom())};
               4: return {1'($urandom()), 8'($urandom_range(150, 160)), 23'($urandom())};
               default: return {1'($urandom()), 8'hFE, 23'h7FFFFF};
            endcase
         default: return half_int_bits($urandom_range(0, 80000) - 40000);
      endcase
   endfunction

   task automatic send_sample(logic [31:0] re_bits, logic [31:0] im_bits);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.real_bits <= re_bits;
      req_if.imag_bits <= im_bits;
      do @(negedge clock); while (!req_if.ready);
      @(posedge clock);
      if ($urandom_range(0, 59) == 0) burst = ~burst;
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_mode(logic [31:0] scale, logic [1:0] fmt);
      drain();
      csr_write(3'(4 * fip_pkg::CSR_SCALE), scale);
      csr_write(3'(4 * fip_pkg::CSR_FORMAT), {30'd0, fmt});
      sb.scale = scale;
      sb.fmt   = fmt;
   endtask

   task automatic run_random(int count);
      repeat (count) send_sample(random_float(sb.scale), random_float(sb.scale));
   endtask

   logic [31:0] phase_scale[12];
   logic [1:0]  phase_fmt[12];

   initial begin
      reset        = 1'b1;
      cycles       = 0;
      stall_left   = 0;
      burst        = 1'b0;
      req_if.valid = 1'b0;
      req_if.real_bits = '0;
      req_if.imag_bits = '0;
      rsp_if.ready = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      phase_scale = '{32'h46FFFE00, 32'h3F800000, 32'h46FFFE00, 32'h3F800000,
                      32'h7F7FFFFF, 32'h00000001, 32'hC7000000, 32'h00000000,
                      32'h7FC00000, 32'h7F800000, 32'h0, 32'h3F000000};
      phase_fmt   = '{fip_pkg::FMT_LE_ITEM32, fip_pkg::FMT_BE_ITEM32,
                      fip_pkg::FMT_NATIVE, 2'd3,
                      fip_pkg::FMT_LE_ITEM32, fip_pkg::FMT_BE_ITEM32,
                      fip_pkg::FMT_NATIVE, fip_pkg::FMT_LE_ITEM32,
                      fip_pkg::FMT_BE_ITEM32, fip_pkg::FMT_NATIVE,
                      fip_pkg::FMT_LE_ITEM32, 2'd3};
      phase_scale[10] = $urandom();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed samples at reset settings
      send_sample(32'h3F800000, 32'hBF800000);
      send_sample(32'h00000000, 32'h80000000);
      send_sample(32'h7F800000, 32'hFF800000);
      send_sample(32'h7FC00000, 32'hFFFFFFFF);
      send_sample(32'h7F7FFFFF, 32'hFF7FFFFF);
      send_sample(32'h00000001, 32'h807FFFFF);
      send_sample(32'h3F000000, 32'hBF000000);
      send_sample(32'h3F800100, 32'hBF800100);
      send_sample(32'h4F000000, 32'hCF000000);
      send_sample(32'h4EFFFFFF, 32'hCEFFFFFF);
      send_sample(32'h40000000, 32'hC0000000);
      send_sample(32'h37000000, 32'hB7800000);
      send_sample(32'hFFFFFFFF, 32'h00000000);
      run_random(PHASE_ITEMS);

      set_mode(32'h3F800000, fip_pkg::FMT_LE_ITEM32);
      send_sample(32'h46FFFE00, 32'hC7000000);
      send_sample(32'h46FFFF00, 32'hC7000080);
      send_sample(32'h47000000, 32'hC7000100);
      send_sample(32'h3FC00000, 32'hC0200000);
      send_sample(32'h4F000000, 32'hCF000000);

      for (int i = 1; i < 12; i++) begin
         set_mode(phase_scale[i], phase_fmt[i]);
         run_random(PHASE_ITEMS);
      end

      drain();
      if (sb.errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
